// File: rtl/pcm_pkg.sv
// Shared constants, codes and interface types of the path corridor merge unit.
`default_nettype none

package pcm_pkg;

    // Store sizes and identifier width
    localparam int PATH_DEPTH    = 256;
    localparam int VISITED_DEPTH = 16;
    localparam int REF_WIDTH     = 32;

    // Derived widths
    localparam int PATH_AW = $clog2(PATH_DEPTH);
    localparam int PATH_LW = $clog2(PATH_DEPTH + 1);
    localparam int VIS_IW  = (VISITED_DEPTH > 1) ? $clog2(VISITED_DEPTH) : 1;
    localparam int VIS_LW  = $clog2(VISITED_DEPTH + 1);
    localparam int OP_W    = 3;
    localparam int CFG_W   = 9;
    localparam int MAX_W   = (PATH_LW > VIS_LW) ?
                             ((PATH_LW > CFG_W) ? PATH_LW : CFG_W) :
                             ((VIS_LW > CFG_W) ? VIS_LW : CFG_W);
    // Merge bookkeeping width, one guard bit over every length involved
    localparam int CALC_W  = MAX_W + 1;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

    typedef enum logic [OP_W-1:0] {
        OP_APPEND_PATH    = 3'd0,
        OP_APPEND_VISITED = 3'd1,
        OP_MERGE          = 3'd2,
        OP_READ           = 3'd3,
        OP_CLEAR          = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_RANGE = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_CALC,
        ST_MOVE,
        ST_TAIL
    } state_t;

    // Commands into the visited list
    typedef struct packed {
        logic append;
        logic clear;
    } vis_cmd_t;

    // Status out of the visited list
    typedef struct packed {
        logic [VIS_LW-1:0] len;
        logic              full;
        logic              hit;
        logic [VIS_IW-1:0] hit_idx;
    } vis_status_t;

endpackage

`default_nettype wire

// File: rtl/path_corridor_merge_unit.sv
// Top level: corridor RAM, visited list and the sequencer for all operations.
// Appends, reads, clears: accept enters EXEC, which registers the result strobe and returns to idle.
// Merge: scans S corridor entries from the end, then moves K kept entries
//   one per cycle through the RAM port pair, then writes T visited tail entries one per cycle.
// Results are pulsed on done for one cycle; the receiver cannot stall.
// Reset (async, active low) empties both lists and sets max_len_reg to 256; stores keep
//   their contents, no clearing pass.
`default_nettype none

module path_corridor_merge_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [pcm_pkg::OP_W-1:0]        operation,
    input  logic [pcm_pkg::REF_WIDTH-1:0]   poly_ref,
    input  logic [pcm_pkg::PATH_AW-1:0]     index,
    input  logic                            cfg_we,
    input  logic [pcm_pkg::CFG_W-1:0]       cfg_wdata,
    output logic                            done,
    output logic [pcm_pkg::PATH_LW-1:0]     path_length,
    output logic [pcm_pkg::REF_WIDTH-1:0]   entry,
    output logic                            found,
    output logic [1:0]                      error
);

    import pcm_pkg::*;

    // Sequencer state
    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    err_t                 err_reg, err_next;
    logic [PATH_LW-1:0]   len_reg, len_next;
    logic [CFG_W-1:0]     max_len_reg;
    logic [PATH_LW-1:0]   ptr_reg, ptr_next;
    logic                 cmpv_reg, cmpv_next;
    logic [PATH_AW-1:0]   cmp_addr_reg, cmp_addr_next;
    logic [PATH_AW-1:0]   hit_pos_reg, hit_pos_next;
    logic [VIS_IW-1:0]    hit_vis_reg, hit_vis_next;
    logic [PATH_LW-1:0]   tail_reg, tail_next;
    logic [PATH_LW-1:0]   keep_reg, keep_next;
    logic [PATH_LW-1:0]   src_reg, src_next;
    logic                 back_reg, back_next;
    logic [PATH_LW-1:0]   cnt_reg, cnt_next;
    logic                 pend_v_reg, pend_v_next;
    logic [PATH_LW-1:0]   pend_off_reg, pend_off_next;

    // Result registers
    logic                 done_reg, done_next;
    logic [PATH_LW-1:0]   count_reg, count_next;
    logic [REF_WIDTH-1:0] entry_reg, entry_next;
    logic                 found_reg, found_next;
    err_t                 error_reg, error_next;

    // Memory and visited list connections
    logic                 ram_we;
    logic [PATH_AW-1:0]   ram_waddr;
    logic [REF_WIDTH-1:0] ram_wdata;
    logic [PATH_AW-1:0]   ram_raddr;
    logic [REF_WIDTH-1:0] ram_rdata;
    vis_cmd_t             vis_cmd;
    logic [VIS_IW-1:0]    vis_rd_idx;
    logic [REF_WIDTH-1:0] vis_rd_data;
    vis_status_t          vis_st;

    logic                 accept;
    op_t                  in_op;

    // Merge bookkeeping
    logic [CALC_W-1:0]    c_tail_raw, c_tail, c_src, c_rest, c_lim, c_keep, c_room;
    logic                 calc_skip;
    logic [PATH_LW-1:0]   mv_off, mv_rd, mv_wr, tail_sum;
    logic [CALC_W-1:0]    t_vidx;

    assign accept = start && (state_reg == ST_IDLE);
    assign in_op  = op_t'(operation);
    assign busy   = (state_reg != ST_IDLE);

    pcm_ram #(
        .DEPTH (PATH_DEPTH),
        .WIDTH (REF_WIDTH),
        .AW    (PATH_AW)
    ) u_corridor (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pcm_visited u_visited (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (vis_cmd),
        .wr_data  (poly_ref),
        .cmp_data (ram_rdata),
        .rd_idx   (vis_rd_idx),
        .rd_data  (vis_rd_data),
        .status   (vis_st)
    );

    // Tail, kept length and move direction after a match
    always_comb
    begin
        c_tail_raw = CALC_W'(vis_st.len) - CALC_W'(hit_vis_reg);
        c_tail     = (c_tail_raw > CALC_W'(PATH_DEPTH)) ? CALC_W'(PATH_DEPTH) : c_tail_raw;
        c_src      = CALC_W'(hit_pos_reg) + CALC_W'(1);
        c_rest     = CALC_W'(len_reg) - c_src;
        c_lim      = (CALC_W'(max_len_reg) > CALC_W'(PATH_DEPTH)) ?
                     CALC_W'(PATH_DEPTH) : CALC_W'(max_len_reg);
        c_room     = CALC_W'(PATH_DEPTH) - c_tail;
        if (c_tail >= c_lim)
        begin
            c_keep = '0;
        end
        else if (c_tail + c_rest > c_lim)
        begin
            c_keep = c_lim - c_tail;
        end
        else
        begin
            c_keep = c_rest;
        end
        if (c_keep > c_room)
        begin
            c_keep = c_room;
        end
        calc_skip = (c_keep == '0) || (c_tail == c_src);
    end

    // Move and tail addressing
    always_comb
    begin
        mv_off   = back_reg ? (keep_reg - PATH_LW'(1) - cnt_reg) : cnt_reg;
        mv_rd    = src_reg + mv_off;
        mv_wr    = tail_reg + pend_off_reg;
        tail_sum = tail_reg + keep_reg;
        t_vidx   = CALC_W'(vis_st.len) - CALC_W'(1) - CALC_W'(cnt_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_op == OP_MERGE) ? ST_SCAN : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (cmpv_reg && vis_st.hit)
                begin
                    state_next = ST_CALC;
                end
                else if (ptr_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CALC:
            begin
                state_next = calc_skip ? ST_TAIL : ST_MOVE;
            end
            ST_MOVE:
            begin
                if ((cnt_reg == keep_reg) && !pend_v_reg)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                if (cnt_reg >= tail_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Datapath control and results
    always_comb
    begin
        op_next       = op_reg;
        err_next      = err_reg;
        len_next      = len_reg;
        ptr_next      = ptr_reg;
        cmpv_next     = 1'b0;
        cmp_addr_next = cmp_addr_reg;
        hit_pos_next  = hit_pos_reg;
        hit_vis_next  = hit_vis_reg;
        tail_next     = tail_reg;
        keep_next     = keep_reg;
        src_next      = src_reg;
        back_next     = back_reg;
        cnt_next      = cnt_reg;
        pend_v_next   = 1'b0;
        pend_off_next = pend_off_reg;
        done_next     = 1'b0;
        count_next    = count_reg;
        entry_next    = entry_reg;
        found_next    = found_reg;
        error_next    = error_reg;
        ram_we        = 1'b0;
        ram_waddr     = len_reg[PATH_AW-1:0];
        ram_wdata     = poly_ref;
        ram_raddr     = index;
        vis_cmd       = '0;
        vis_rd_idx    = t_vidx[VIS_IW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next  = in_op;
                    err_next = ERR_NONE;
                    ptr_next = len_reg;
                    unique case (in_op)
                        OP_APPEND_PATH:
                        begin
                            if (len_reg == PATH_LW'(PATH_DEPTH))
                            begin
                                err_next = ERR_FULL;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                len_next = len_reg + PATH_LW'(1);
                            end
                        end
                        OP_APPEND_VISITED:
                        begin
                            if (vis_st.full)
                            begin
                                err_next = ERR_FULL;
                            end
                            else
                            begin
                                vis_cmd.append = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (PATH_LW'(index) >= len_reg)
                            begin
                                err_next = ERR_RANGE;
                            end
                        end
                        OP_CLEAR:
                        begin
                            len_next      = '0;
                            vis_cmd.clear = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                done_next  = 1'b1;
                count_next = len_reg;
                entry_next = ((op_reg == OP_READ) && (err_reg == ERR_NONE)) ? ram_rdata : '0;
                found_next = 1'b0;
                error_next = err_reg;
            end
            ST_SCAN:
            begin
                // Walk the corridor from its end, one read per cycle
                ram_raddr = PATH_AW'(ptr_reg - PATH_LW'(1));
                if (cmpv_reg && vis_st.hit)
                begin
                    hit_pos_next = cmp_addr_reg;
                    hit_vis_next = vis_st.hit_idx;
                end
                else if (ptr_reg == '0)
                begin
                    done_next     = 1'b1;
                    count_next    = len_reg;
                    entry_next    = '0;
                    found_next    = 1'b0;
                    error_next    = ERR_NONE;
                    vis_cmd.clear = 1'b1;
                end
                else
                begin
                    ptr_next      = ptr_reg - PATH_LW'(1);
                    cmpv_next     = 1'b1;
                    cmp_addr_next = PATH_AW'(ptr_reg - PATH_LW'(1));
                end
            end
            ST_CALC:
            begin
                tail_next = c_tail[PATH_LW-1:0];
                keep_next = c_keep[PATH_LW-1:0];
                src_next  = c_src[PATH_LW-1:0];
                back_next = (c_tail > c_src);
                cnt_next  = '0;
            end
            ST_MOVE:
            begin
                // Read source, write destination in the next cycle
                ram_raddr = mv_rd[PATH_AW-1:0];
                if (cnt_reg != keep_reg)
                begin
                    cnt_next      = cnt_reg + PATH_LW'(1);
                    pend_v_next   = 1'b1;
                    pend_off_next = mv_off;
                end
                if (pend_v_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = mv_wr[PATH_AW-1:0];
                    ram_wdata = ram_rdata;
                end
                if ((cnt_reg == keep_reg) && !pend_v_reg)
                begin
                    cnt_next = '0;
                end
            end
            ST_TAIL:
            begin
                // Reversed visited tail into the corridor head
                if (cnt_reg < tail_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg[PATH_AW-1:0];
                    ram_wdata = vis_rd_data;
                    cnt_next  = cnt_reg + PATH_LW'(1);
                end
                else
                begin
                    len_next      = tail_sum;
                    done_next     = 1'b1;
                    count_next    = tail_sum;
                    entry_next    = '0;
                    found_next    = 1'b1;
                    error_next    = ERR_NONE;
                    vis_cmd.clear = 1'b1;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            max_len_reg <= CFG_RESET;
            done_reg    <= 1'b0;
            cmpv_reg    <= 1'b0;
            pend_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            done_reg   <= done_next;
            cmpv_reg   <= cmpv_next;
            pend_v_reg <= pend_v_next;
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        err_reg      <= err_next;
        ptr_reg      <= ptr_next;
        cmp_addr_reg <= cmp_addr_next;
        hit_pos_reg  <= hit_pos_next;
        hit_vis_reg  <= hit_vis_next;
        tail_reg     <= tail_next;
        keep_reg     <= keep_next;
        src_reg      <= src_next;
        back_reg     <= back_next;
        cnt_reg      <= cnt_next;
        pend_off_reg <= pend_off_next;
        count_reg    <= count_next;
        entry_reg    <= entry_next;
        found_reg    <= found_next;
        error_reg    <= error_next;
    end

    assign done        = done_reg;
    assign path_length = count_reg;
    assign entry       = entry_reg;
    assign found       = found_reg;
    assign error       = error_reg;

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted transaction did not raise busy");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= PATH_LW'(PATH_DEPTH))
        else $error("corridor length beyond depth");

    a_move_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MOVE) && pend_v_reg) |-> (mv_wr < tail_sum))
        else $error("corridor move writes past new length");
`endif

endmodule

`default_nettype wire

// File: rtl/pcm_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
`default_nettype none

module pcm_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered output
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/pcm_visited.sv
// Visited polygon list: register file, fill length, parallel match and tail read.
`default_nettype none

module pcm_visited (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pcm_pkg::vis_cmd_t               cmd,
    input  logic [pcm_pkg::REF_WIDTH-1:0]   wr_data,
    input  logic [pcm_pkg::REF_WIDTH-1:0]   cmp_data,
    input  logic [pcm_pkg::VIS_IW-1:0]      rd_idx,
    output logic [pcm_pkg::REF_WIDTH-1:0]   rd_data,
    output pcm_pkg::vis_status_t            status
);

    import pcm_pkg::*;

    logic [REF_WIDTH-1:0] store [VISITED_DEPTH];
    logic [VIS_LW-1:0]    len_reg;
    logic [VIS_LW-1:0]    len_next;
    logic                 full;
    logic                 hit;
    logic [VIS_IW-1:0]    hit_idx;

    assign full = (len_reg == VIS_LW'(VISITED_DEPTH));

    // Length update
    always_comb
    begin
        len_next = len_reg;
        if (cmd.clear)
        begin
            len_next = '0;
        end
        else if (cmd.append && !full)
        begin
            len_next = len_reg + VIS_LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    // Entry write at the fill position
    always_ff @(posedge clk)
    begin
        if (cmd.append && !full && !cmd.clear)
        begin
            store[len_reg[VIS_IW-1:0]] <= wr_data;
        end
    end

    // Compare all valid entries, lowest matching position wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int v = VISITED_DEPTH - 1; v >= 0; v--)
        begin
            if ((VIS_LW'(v) < len_reg) && (store[v] == cmp_data))
            begin
                hit     = 1'b1;
                hit_idx = VIS_IW'(v);
            end
        end
    end

    assign rd_data = store[rd_idx];

    always_comb
    begin
        status.len     = len_reg;
        status.full    = full;
        status.hit     = hit;
        status.hit_idx = hit_idx;
    end

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= VIS_LW'(VISITED_DEPTH))
        else $error("visited length beyond depth");

    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> (VIS_LW'(hit_idx) < len_reg))
        else $error("match reported on an empty position");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.append && !cmd.clear && !full) |=> (len_reg == $past(len_reg) + VIS_LW'(1)))
        else $error("append did not extend visited list");
`endif

endmodule

`default_nettype wire
